### sv/i2c_rac_pkg.sv
// shared types, constants and the pin-step program lookup for the i2c register access master
package i2c_rac_pkg;

   // pin-step operations of one transaction program
   typedef enum logic [3:0] {
      OP_START,
      OP_WA,
      OP_WA1,
      OP_WR,
      OP_WD,
      OP_ACK,
      OP_RD,
      OP_NOACK,
      OP_STOP,
      OP_DELAY
   } op_type;

   localparam int PhaseWidth = 4;
   localparam int WaitWidth  = 16;

   localparam logic [PhaseWidth-1:0] PHASE_IDLE       = 4'd0;
   localparam logic [PhaseWidth-1:0] PHASE_FIRST      = 4'd1;
   localparam logic [PhaseWidth-1:0] PHASE_WRITE_STOP = 4'd8;
   localparam logic [PhaseWidth-1:0] PHASE_READ_STOP  = 4'd11;

   localparam logic [WaitWidth-1:0] WAIT_MAX = 16'hFFFF;

   // register map
   localparam logic [0:0] REG_POST_WRITE_DELAY = 1'b0;
   localparam logic [0:0] REG_ACK_TIMEOUT      = 1'b1;

   localparam logic [15:0] POST_WRITE_DELAY_RESET = 16'd1000;
   localparam logic [15:0] ACK_TIMEOUT_RESET      = 16'd0;

   // transaction state carried from one item to the next
   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic [2:0]            bit_count;
      logic [1:0]            byte_step;
      logic [7:0]            shift_byte;
      logic                  is_read;
      logic [7:0]            address_byte;
      logic [7:0]            register_byte;
      logic [7:0]            write_byte;
      logic [WaitWidth-1:0]  wait_count;
      logic [7:0]            received_byte;
      logic                  scl;
      logic                  sda;
      logic                  abort;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:         PHASE_IDLE,
      bit_count:     3'd0,
      byte_step:     2'd0,
      shift_byte:    8'd0,
      is_read:       1'b0,
      address_byte:  8'd0,
      register_byte: 8'd0,
      write_byte:    8'd0,
      wait_count:    16'd0,
      received_byte: 8'd0,
      scl:           1'b1,
      sda:           1'b1,
      abort:         1'b0
   };

   // item step flags handed from the step logic to the result register
   typedef struct packed {
      logic accepted;
      logic done;
   } step_flags_type;

   // operation for a given program position; positions past the end fall to stop
   function automatic op_type current_op(input logic [PhaseWidth-1:0] phase,
                                         input logic                  is_read);
      op_type op;
      op = OP_STOP;
      if (is_read) begin
         case (phase)
            4'd1:    op = OP_START;
            4'd2:    op = OP_WA;
            4'd3:    op = OP_ACK;
            4'd4:    op = OP_WR;
            4'd5:    op = OP_ACK;
            4'd6:    op = OP_START;
            4'd7:    op = OP_WA1;
            4'd8:    op = OP_ACK;
            4'd9:    op = OP_RD;
            4'd10:   op = OP_NOACK;
            default: op = OP_STOP;
         endcase
      end else begin
         case (phase)
            4'd1:    op = OP_START;
            4'd2:    op = OP_WA;
            4'd3:    op = OP_ACK;
            4'd4:    op = OP_WR;
            4'd5:    op = OP_ACK;
            4'd6:    op = OP_WD;
            4'd7:    op = OP_ACK;
            4'd9:    op = OP_DELAY;
            default: op = OP_STOP;
         endcase
      end
      return op;
   endfunction

endpackage

### sv/i2c_rac_step.sv
// next-state logic for one request or tick item of the i2c register access master
module i2c_rac_step (
   input  i2c_rac_pkg::state_type      cur_state,
   input  logic                        kind,
   input  logic                        is_read,
   input  logic [7:0]                  address_byte,
   input  logic [7:0]                  register_byte,
   input  logic [7:0]                  write_byte,
   input  logic                        sda_sample,
   input  logic [15:0]                 post_write_delay,
   input  logic [15:0]                 ack_timeout,
   output i2c_rac_pkg::state_type      next_state,
   output i2c_rac_pkg::step_flags_type flags
);

   i2c_rac_pkg::op_type op;
   logic [2:0]          bit_sel;
   logic [7:0]          tx_byte;
   logic [15:0]         wait_inc;
   logic [15:0]         wait_dec;

   // program position and the byte being shifted out
   always_comb begin
      op      = i2c_rac_pkg::current_op(cur_state.phase, cur_state.is_read);
      bit_sel = 3'd7 - cur_state.bit_count;
      case (op)
         i2c_rac_pkg::OP_WA:  tx_byte = cur_state.address_byte;
         i2c_rac_pkg::OP_WA1: tx_byte = cur_state.address_byte | 8'd1;
         i2c_rac_pkg::OP_WR:  tx_byte = cur_state.register_byte;
         default:             tx_byte = cur_state.write_byte;
      endcase
      wait_inc = (cur_state.wait_count < i2c_rac_pkg::WAIT_MAX) ?
                 cur_state.wait_count + 16'd1 : cur_state.wait_count;
      wait_dec = (cur_state.wait_count != 16'd0) ?
                 cur_state.wait_count - 16'd1 : cur_state.wait_count;
   end

   // one pin step per tick, or a request load when idle
   always_comb begin
      next_state     = cur_state;
      flags.accepted = 1'b0;
      flags.done     = 1'b0;
      if (kind) begin
         if (cur_state.phase == i2c_rac_pkg::PHASE_IDLE) begin
            next_state.is_read       = is_read;
            next_state.address_byte  = address_byte;
            next_state.register_byte = register_byte;
            next_state.write_byte    = write_byte;
            next_state.phase         = i2c_rac_pkg::PHASE_FIRST;
            next_state.byte_step     = 2'd0;
            next_state.bit_count     = 3'd0;
            next_state.shift_byte    = 8'd0;
            next_state.wait_count    = 16'd0;
            next_state.abort         = 1'b0;
            flags.accepted           = 1'b1;
         end
      end else if (cur_state.phase != i2c_rac_pkg::PHASE_IDLE) begin
         case (op)
            i2c_rac_pkg::OP_START: begin
               if (cur_state.byte_step == 2'd0) begin
                  next_state.scl       = 1'b1;
                  next_state.byte_step = 2'd1;
               end else if (cur_state.byte_step == 2'd1) begin
                  next_state.sda       = 1'b1;
                  next_state.byte_step = 2'd2;
               end else begin
                  next_state.sda       = 1'b0;
                  next_state.phase     = cur_state.phase + 4'd1;
                  next_state.byte_step = 2'd0;
                  next_state.bit_count = 3'd0;
               end
            end
            i2c_rac_pkg::OP_WA, i2c_rac_pkg::OP_WA1,
            i2c_rac_pkg::OP_WR, i2c_rac_pkg::OP_WD: begin
               if (cur_state.byte_step == 2'd0) begin
                  next_state.scl       = 1'b0;
                  next_state.byte_step = 2'd1;
               end else if (cur_state.byte_step == 2'd1) begin
                  next_state.sda       = tx_byte[bit_sel];
                  next_state.byte_step = 2'd2;
               end else begin
                  next_state.scl = 1'b1;
                  if (cur_state.bit_count == 3'd7) begin
                     next_state.phase     = cur_state.phase + 4'd1;
                     next_state.byte_step = 2'd0;
                     next_state.bit_count = 3'd0;
                  end else begin
                     next_state.bit_count = cur_state.bit_count + 3'd1;
                     next_state.byte_step = 2'd0;
                  end
               end
            end
            i2c_rac_pkg::OP_ACK: begin
               if (cur_state.byte_step == 2'd0) begin
                  next_state.scl       = 1'b0;
                  next_state.byte_step = 2'd1;
               end else if (cur_state.byte_step == 2'd1) begin
                  next_state.sda       = 1'b1;
                  next_state.byte_step = 2'd2;
               end else if (cur_state.byte_step == 2'd2) begin
                  next_state.scl        = 1'b1;
                  next_state.wait_count = 16'd0;
                  next_state.byte_step  = 2'd3;
               end else if (!sda_sample) begin
                  next_state.scl       = 1'b0;
                  next_state.phase     = cur_state.phase + 4'd1;
                  next_state.byte_step = 2'd0;
                  next_state.bit_count = 3'd0;
               end else if (ack_timeout != 16'd0) begin
                  next_state.wait_count = wait_inc;
                  // timed out: abort into the stop sequence
                  if (wait_inc >= ack_timeout) begin
                     next_state.abort     = 1'b1;
                     next_state.phase     = cur_state.is_read ?
                                            i2c_rac_pkg::PHASE_READ_STOP :
                                            i2c_rac_pkg::PHASE_WRITE_STOP;
                     next_state.byte_step = 2'd0;
                     next_state.bit_count = 3'd0;
                  end
               end
            end
            i2c_rac_pkg::OP_RD: begin
               if (cur_state.byte_step == 2'd0) begin
                  next_state.scl = 1'b1;
                  if (sda_sample) begin
                     next_state.shift_byte[bit_sel] = 1'b1;
                  end
                  next_state.byte_step = 2'd1;
               end else begin
                  next_state.scl = 1'b0;
                  if (cur_state.bit_count == 3'd7) begin
                     next_state.received_byte = cur_state.shift_byte;
                     next_state.phase         = cur_state.phase + 4'd1;
                     next_state.byte_step     = 2'd0;
                     next_state.bit_count     = 3'd0;
                  end else begin
                     next_state.bit_count = cur_state.bit_count + 3'd1;
                     next_state.byte_step = 2'd0;
                  end
               end
            end
            i2c_rac_pkg::OP_NOACK: begin
               if (cur_state.byte_step == 2'd0) begin
                  next_state.scl       = 1'b0;
                  next_state.byte_step = 2'd1;
               end else if (cur_state.byte_step == 2'd1) begin
                  next_state.sda       = 1'b1;
                  next_state.byte_step = 2'd2;
               end else begin
                  next_state.scl       = 1'b1;
                  next_state.phase     = cur_state.phase + 4'd1;
                  next_state.byte_step = 2'd0;
                  next_state.bit_count = 3'd0;
               end
            end
            i2c_rac_pkg::OP_STOP: begin
               if (cur_state.byte_step == 2'd0) begin
                  next_state.scl       = 1'b0;
                  next_state.byte_step = 2'd1;
               end else if (cur_state.byte_step == 2'd1) begin
                  next_state.sda       = 1'b0;
                  next_state.byte_step = 2'd2;
               end else if (cur_state.byte_step == 2'd2) begin
                  next_state.scl       = 1'b1;
                  next_state.byte_step = 2'd3;
               end else begin
                  next_state.sda = 1'b1;
                  if (!cur_state.is_read && !cur_state.abort &&
                      post_write_delay != 16'd0) begin
                     next_state.phase      = cur_state.phase + 4'd1;
                     next_state.byte_step  = 2'd0;
                     next_state.bit_count  = 3'd0;
                     next_state.wait_count = post_write_delay;
                  end else begin
                     next_state.phase     = i2c_rac_pkg::PHASE_IDLE;
                     next_state.byte_step = 2'd0;
                     next_state.bit_count = 3'd0;
                     flags.done           = 1'b1;
                  end
               end
            end
            default: begin
               // post-write delay countdown
               next_state.wait_count = wait_dec;
               if (wait_dec == 16'd0) begin
                  next_state.phase     = i2c_rac_pkg::PHASE_IDLE;
                  next_state.byte_step = 2'd0;
                  next_state.bit_count = 3'd0;
                  flags.done           = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

### sv/i2c_register_access_master_top.sv
// top level of the i2c register access master: channels, state and result registers, csr port
//
// A request transfer (req_kind 1) loads a one-register read or write transaction
// when the block is idle; while busy it is answered with rsp_accepted 0 and
// changes nothing. Each tick transfer (req_kind 0) carries the sampled SDA level
// and, while busy, performs one SCL/SDA pin step; its result gives the pin levels after it.
// Every input transfer yields exactly one result transfer.
// The result is registered; throughput is one item per cycle while the receiver
// takes results, set by the single state register updated from the step logic.
// A new item is taken whenever the result register is empty or being drained
// in the same cycle, so a stalled receiver holds the result and backs up the
// input channel after one item.
// The csr port holds post_write_delay (address 0) and ack_timeout (address 4);
// pready is always high, writes land on the access cycle.
// Synchronous reset returns to idle with both pins high, post_write_delay 1000,
// ack_timeout 0 and no result pending.
module i2c_register_access_master_top (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic        req_is_read,
   input  logic [7:0]  req_address_byte,
   input  logic [7:0]  req_register_byte,
   input  logic [7:0]  req_write_byte,
   input  logic        req_sda_sample,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_busy_res,
   output logic        rsp_accepted,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_ack_missing,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   i2c_rac_pkg::state_type      state_ff;
   i2c_rac_pkg::state_type      state_in;
   i2c_rac_pkg::step_flags_type flags;
   logic [15:0]                 post_write_delay_ff;
   logic [15:0]                 ack_timeout_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_accepted_ff;
   logic                        rsp_done_res_ff;
   logic                        req_fire;
   logic                        csr_write;

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // step logic
   i2c_rac_step u_step (
      .cur_state        (state_ff),
      .kind             (req_kind),
      .is_read          (req_is_read),
      .address_byte     (req_address_byte),
      .register_byte    (req_register_byte),
      .write_byte       (req_write_byte),
      .sda_sample       (req_sda_sample),
      .post_write_delay (post_write_delay_ff),
      .ack_timeout      (ack_timeout_ff),
      .next_state       (state_in),
      .flags            (flags)
   );

   // transaction state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2c_rac_pkg::STATE_RESET;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         rsp_accepted_ff <= 1'b0;
         rsp_done_res_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff    <= 1'b1;
         rsp_accepted_ff <= flags.accepted;
         rsp_done_res_ff <= flags.done;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // the pin, busy, read byte and ack_missing fields come straight from the state just written
   assign rsp_scl_level   = state_ff.scl;
   assign rsp_sda_level   = state_ff.sda;
   assign rsp_busy_res    = state_ff.phase != i2c_rac_pkg::PHASE_IDLE;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_done_res    = rsp_done_res_ff;
   assign rsp_read_byte   = state_ff.received_byte;
   assign rsp_ack_missing = state_ff.abort;

   // csr registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         post_write_delay_ff <= i2c_rac_pkg::POST_WRITE_DELAY_RESET;
         ack_timeout_ff      <= i2c_rac_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            i2c_rac_pkg::REG_POST_WRITE_DELAY: post_write_delay_ff <= csr_pwdata[15:0];
            i2c_rac_pkg::REG_ACK_TIMEOUT:      ack_timeout_ff      <= csr_pwdata[15:0];
            default:                           ack_timeout_ff      <= ack_timeout_ff;
         endcase
      end
   end

   // csr read back
   always_comb begin
      case (csr_paddr[2])
         i2c_rac_pkg::REG_POST_WRITE_DELAY: csr_prdata = {16'd0, post_write_delay_ff};
         i2c_rac_pkg::REG_ACK_TIMEOUT:      csr_prdata = {16'd0, ack_timeout_ff};
         default:                           csr_prdata = 32'd0;
      endcase
   end

   // a request taken while idle starts a transaction
   a_request_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_kind && state_ff.phase == i2c_rac_pkg::PHASE_IDLE
      |=> rsp_accepted_ff && rsp_busy_res && !rsp_done_res_ff)
      else $error("idle request did not start a transaction");

   // the end of a transaction leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_res_ff |-> !rsp_busy_res)
      else $error("transaction ended but block still busy");

   // a tick while idle does nothing to the pins or phase
   a_idle_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_kind && state_ff.phase == i2c_rac_pkg::PHASE_IDLE
      |=> state_ff.phase == i2c_rac_pkg::PHASE_IDLE && $stable(state_ff.scl)
          && $stable(state_ff.sda) && !rsp_done_res_ff)
      else $error("tick while idle changed state");

   // a request while busy is refused and leaves the held request alone
   a_busy_refuse: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_kind && state_ff.phase != i2c_rac_pkg::PHASE_IDLE
      |=> !rsp_accepted_ff && $stable(state_ff.address_byte) && $stable(state_ff.phase))
      else $error("request while busy was not refused");

endmodule
